FILE: hdl/ctms_pkg.sv
// shared types and constants for the cron time match scanner
`timescale 1ns / 1ps
`default_nettype none

package ctms_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam int unsigned SLOT_CAP        = 16;

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned MINUTE_W  = 60;
  localparam int unsigned HOUR_W    = 24;
  localparam int unsigned DAY_W     = 31;
  localparam int unsigned MONTH_W   = 12;
  localparam int unsigned WEEKDAY_W = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic [MINUTE_W-1:0]  minute;
    logic [HOUR_W-1:0]    hour;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [WEEKDAY_W-1:0] weekday;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } scan_state_e;

endpackage

`default_nettype wire

FILE: hdl/cron_time_match_scan.sv
// cron schedule table with a sequential per-tick match scan
//
// Input channel (in_valid_i / in_stall_o): one beat is either a write command,
// which stores five masks at entry_index_i, or a tick carrying the current time.
// A write returns nothing. A tick scans the table one entry per cycle, unless a
// stalled output holds it, in ascending index order out of a single-port memory
// with a registered read, and returns one beat per due entry, or one beat with
// matched_o low if none is due; last_o marks the final beat of the tick.
// A tick steps through ST_SCAN, ST_DRAIN and ST_FINISH before it returns to
// ST_IDLE; in_stall_o stays high for the whole scan.
// Output channel (out_valid_o / out_stall_i): results sit in an output register.
// While the receiver stalls, the scan holds at the entry that needs to emit and
// resumes when the register frees up; the next tick can be taken while the
// final beat of the previous one still waits.
// Reset clears every entry's valid flag, so all entries read as disabled, and
// empties the output register. Only slots below min(NUM_ENTRIES, 16) are writable and reported.
`timescale 1ns / 1ps
`default_nettype none

module cron_time_match_scan
  import ctms_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 command_i,
  input  wire logic [IDX_W-1:0]     entry_index_i,
  input  wire logic [MINUTE_W-1:0]  minute_mask_i,
  input  wire logic [HOUR_W-1:0]    hour_mask_i,
  input  wire logic [DAY_W-1:0]     day_mask_i,
  input  wire logic [MONTH_W-1:0]   month_mask_i,
  input  wire logic [WEEKDAY_W-1:0] weekday_mask_i,
  input  wire logic [5:0]           minute_i,
  input  wire logic [4:0]           hour_i,
  input  wire logic [4:0]           day_of_month_i,
  input  wire logic [3:0]           month_i,
  input  wire logic [2:0]           weekday_i,

  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      matched_o,
  output logic [IDX_W-1:0]          job_index_o,
  output logic                      last_o
);

  localparam int unsigned AW     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned SCAN_N = (NUM_ENTRIES < SLOT_CAP) ? NUM_ENTRIES : SLOT_CAP;

  // table storage
  entry_t                 mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_q;
  entry_t                 rdata_q;
  logic                   ent_vld_q;

  // current time as one-hot selects
  logic [MINUTE_W-1:0]  min_oh_q;
  logic [HOUR_W-1:0]    hour_oh_q;
  logic [DAY_W-1:0]     day_oh_q;
  logic [MONTH_W-1:0]   month_oh_q;
  logic [WEEKDAY_W-1:0] wday_oh_q;

  scan_state_e state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          eval_vld_q, eval_vld_d;
  logic [AW-1:0] eval_idx_q, eval_idx_d;
  logic          pend_vld_q, pend_vld_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;

  logic             out_vld_q, out_vld_d;
  logic             matched_q, matched_d;
  logic [IDX_W-1:0] job_q, job_d;
  logic             last_q, last_d;

  logic          in_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic          match;
  logic          hit;
  logic          emit_mid;
  logic          out_free;
  logic          advance;
  logic          out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = in_acc && (command_i == CMD_WRITE)
                      && (32'(entry_index_i) < 32'(NUM_ENTRIES));
  assign wr_addr    = AW'(entry_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{minute:  minute_mask_i,
                        hour:    hour_mask_i,
                        day:     day_mask_i,
                        month:   month_mask_i,
                        weekday: weekday_mask_i};
    end
    if (rd_en) begin
      rdata_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      ent_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        ent_vld_q <= vld_q[ptr_q];
      end
    end
  end

  // out-of-range time values shift out and select nothing
  always_ff @(posedge clk_i) begin
    if (in_acc && (command_i == CMD_TICK)) begin
      min_oh_q   <= MINUTE_W'(1) << minute_i;
      hour_oh_q  <= HOUR_W'(1) << hour_i;
      day_oh_q   <= DAY_W'(1) << (day_of_month_i - 5'd1);
      month_oh_q <= MONTH_W'(1) << (month_i - 4'd1);
      wday_oh_q  <= WEEKDAY_W'(1) << weekday_i;
    end
  end

  assign match = (|(rdata_q.minute & min_oh_q)) && (|(rdata_q.hour & hour_oh_q))
                 && (|(rdata_q.day & day_oh_q)) && (|(rdata_q.month & month_oh_q))
                 && (|(rdata_q.weekday & wday_oh_q));

  assign hit      = eval_vld_q && ent_vld_q && match;
  assign emit_mid = hit && pend_vld_q;
  assign out_free = !out_vld_q || !out_stall_i;
  assign advance  = !(emit_mid && !out_free);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    eval_vld_d = eval_vld_q;
    eval_idx_d = eval_idx_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    matched_d  = matched_q;
    job_d      = job_q;
    last_d     = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (command_i == CMD_TICK)) begin
          ptr_d      = '0;
          pend_vld_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          rd_en      = 1'b1;
          eval_vld_d = 1'b1;
          eval_idx_d = ptr_q;
          if (ptr_q == AW'(SCAN_N - 1)) begin
            state_d = ST_DRAIN;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (advance) begin
          eval_vld_d = 1'b0;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          matched_d  = pend_vld_q;
          job_d      = pend_vld_q ? IDX_W'(pend_idx_q) : '0;
          last_d     = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a new hit pushes the previous one out, not marked last
    if (advance && hit) begin
      pend_vld_d = 1'b1;
      pend_idx_d = eval_idx_q;
      if (emit_mid) begin
        out_load  = 1'b1;
        matched_d = 1'b1;
        job_d     = IDX_W'(pend_idx_q);
        last_d    = 1'b0;
      end
    end

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ptr_q      <= '0;
      eval_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      eval_vld_q <= eval_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= eval_idx_d;
    pend_idx_q <= pend_idx_d;
    matched_q  <= matched_d;
    job_q      <= job_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_vld_q;
  assign matched_o   = matched_q;
  assign job_index_o = job_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
